>>> hw/rtl/ascii_integer_parser_top_macros.svh
// ----------------------------------------------------------------------------
// ascii_integer_parser_top_macros
// Assertion macros used by the parser core.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_TOP_MACROS_SVH
`define ASCII_INTEGER_PARSER_TOP_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define AIP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define AIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Types, constants and the digit decoder of the ASCII integer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aip_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int OFFSET_BITS = 10;
    localparam int CH_BITS     = 8;
    localparam int RADIX_BITS  = 6;
    localparam int STATUS_BITS = 2;
    localparam int PROD_BITS   = VALUE_BITS + RADIX_BITS;

    localparam logic [RADIX_BITS-1:0] RADIX_AUTO  = RADIX_BITS'(0);
    localparam logic [RADIX_BITS-1:0] RADIX_ONE   = RADIX_BITS'(1);
    localparam logic [RADIX_BITS-1:0] RADIX_BIN   = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_OCT   = RADIX_BITS'(8);
    localparam logic [RADIX_BITS-1:0] RADIX_DEC   = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = RADIX_BITS'(16);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = RADIX_BITS'(36);
    localparam logic [RADIX_BITS-1:0] DIGIT_NONE  = '1;

    localparam logic [CH_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_BITS-1:0] CH_LOW_X  = 8'h78;
    localparam logic [CH_BITS-1:0] CH_UP_X   = 8'h58;
    localparam logic [CH_BITS-1:0] CH_LOW_B  = 8'h62;
    localparam logic [CH_BITS-1:0] CH_UP_B   = 8'h42;
    localparam logic [CH_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_BITS-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_BITS-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CH_BITS-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CH_BITS-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [CH_BITS-1:0] ALPHA_OFS = 8'd10;

    localparam logic [STATUS_BITS-1:0] ST_NONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_VALID = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVF   = 2'd2;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_WS,
        PH_LEAD,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        logic [CH_BITS-1:0]    ch;
        logic [RADIX_BITS-1:0] radix;
        logic                  first;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [OFFSET_BITS-1:0]       end_offset;
        logic [STATUS_BITS-1:0]       status;
    } t_out_item;

    function automatic logic [RADIX_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
        logic [RADIX_BITS-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = RADIX_BITS'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = RADIX_BITS'(c - CH_UP_A + ALPHA_OFS);
        end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            d = RADIX_BITS'(c - CH_LOW_A + ALPHA_OFS);
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/aip_core.sv
// ----------------------------------------------------------------------------
// aip_core
// Parse state and step logic: one character per fire.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_integer_parser_top_macros.svh"

module aip_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  aip_pkg::t_in_item i_item,
    output logic              o_emit,
    output aip_pkg::t_out_item o_result
);

    localparam int VB = aip_pkg::VALUE_BITS;
    localparam int OB = aip_pkg::OFFSET_BITS;
    localparam int RB = aip_pkg::RADIX_BITS;
    localparam int PB = aip_pkg::PROD_BITS;
    localparam logic [VB-1:0] VAL_MAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0] VAL_MIN = {1'b1, {(VB-1){1'b0}}};

    aip_pkg::t_phase r_phase, n_phase;
    logic [RB-1:0]   r_base, n_base;
    logic            r_neg, n_neg;
    logic [VB-1:0]   r_acc, n_acc;
    logic [1:0]      r_ds, n_ds;
    logic [OB-1:0]   r_pos, n_pos;
    logic [OB-1:0]   r_pend, n_pend;

    logic            bad_radix;
    aip_pkg::t_phase eph;
    logic [RB-1:0]   e_base;
    logic            e_neg;
    logic [VB-1:0]   e_acc;
    logic [1:0]      e_ds;
    logic [OB-1:0]   e_pos;
    logic [OB-1:0]   e_pend;
    logic [OB-1:0]   pos_inc;

    logic [RB-1:0]   dig;
    logic [RB-1:0]   tb;
    logic            is_ws, is_minus, is_plus, is_sign;
    logic            base_zero_ok, base_x_ok, base_b_ok;
    logic            ws_skip, sign_take, in_lead, lead_zero, x_pre, b_pre, pre;
    logic            take, d_ok, prefix_fail, finish, accept_digit, advance;
    logic [PB-1:0]   prod, limit;
    logic            ovf;

    assign bad_radix = i_item.first &&
                       (i_item.radix == aip_pkg::RADIX_ONE || i_item.radix > aip_pkg::RADIX_MAX);
    assign eph    = i_item.first ? (bad_radix ? aip_pkg::PH_DONE : aip_pkg::PH_WS) : r_phase;
    assign e_base = i_item.first ? i_item.radix : r_base;
    assign e_neg  = i_item.first ? 1'b0 : r_neg;
    assign e_acc  = i_item.first ? '0 : r_acc;
    assign e_ds   = i_item.first ? aip_pkg::ST_NONE : r_ds;
    assign e_pos  = i_item.first ? '0 : r_pos;
    assign e_pend = i_item.first ? '0 : r_pend;
    assign pos_inc = (e_pos != '1) ? e_pos + 1'b1 : e_pos;

    assign dig      = aip_pkg::digit_of(i_item.ch);
    assign is_ws    = i_item.ch == aip_pkg::CH_SPACE || i_item.ch == aip_pkg::CH_TAB;
    assign is_minus = i_item.ch == aip_pkg::CH_MINUS;
    assign is_plus  = i_item.ch == aip_pkg::CH_PLUS;
    assign is_sign  = is_minus || is_plus;

    assign base_x_ok    = e_base == aip_pkg::RADIX_AUTO || e_base == aip_pkg::RADIX_HEX;
    assign base_b_ok    = e_base == aip_pkg::RADIX_AUTO || e_base == aip_pkg::RADIX_BIN;
    assign base_zero_ok = base_x_ok || e_base == aip_pkg::RADIX_BIN;

    assign ws_skip   = eph == aip_pkg::PH_WS && is_ws;
    assign sign_take = eph == aip_pkg::PH_WS && is_sign;
    assign in_lead   = (eph == aip_pkg::PH_WS && !is_ws && !is_sign) ||
                       eph == aip_pkg::PH_LEAD;
    assign lead_zero = in_lead && i_item.ch == aip_pkg::CH_ZERO && base_zero_ok;
    assign x_pre     = eph == aip_pkg::PH_ZERO && base_x_ok &&
                       (i_item.ch == aip_pkg::CH_LOW_X || i_item.ch == aip_pkg::CH_UP_X);
    assign b_pre     = eph == aip_pkg::PH_ZERO && base_b_ok && !x_pre &&
                       (i_item.ch == aip_pkg::CH_LOW_B || i_item.ch == aip_pkg::CH_UP_B);
    assign pre       = x_pre || b_pre;

    always_comb begin
        unique case (eph)
            aip_pkg::PH_WS, aip_pkg::PH_LEAD: begin
                tb = (e_base == aip_pkg::RADIX_AUTO) ? aip_pkg::RADIX_DEC : e_base;
            end
            aip_pkg::PH_ZERO: begin
                tb = (e_base == aip_pkg::RADIX_AUTO) ? aip_pkg::RADIX_OCT : e_base;
            end
            default: begin
                tb = e_base;
            end
        endcase
    end

    assign take = (in_lead && !lead_zero) || (eph == aip_pkg::PH_ZERO && !pre) ||
                  eph == aip_pkg::PH_PREFIX || eph == aip_pkg::PH_DIGITS;
    assign d_ok         = dig < tb;
    assign prefix_fail  = eph == aip_pkg::PH_PREFIX && !d_ok;
    assign finish       = take && !d_ok && eph != aip_pkg::PH_PREFIX;
    assign accept_digit = take && d_ok;
    assign advance      = ws_skip || sign_take || lead_zero || pre || accept_digit;

    assign prod  = PB'(e_acc) * PB'(tb) + PB'(dig);
    assign limit = PB'(VAL_MAX) + PB'(e_neg);
    assign ovf   = prod > limit;

    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            n_phase = eph;
            if (o_emit) begin
                n_phase = aip_pkg::PH_DONE;
            end else if (sign_take) begin
                n_phase = aip_pkg::PH_LEAD;
            end else if (lead_zero) begin
                n_phase = aip_pkg::PH_ZERO;
            end else if (pre) begin
                n_phase = aip_pkg::PH_PREFIX;
            end else if (accept_digit) begin
                n_phase = aip_pkg::PH_DIGITS;
            end
        end
    end

    always_comb begin
        n_base = e_base;
        n_neg  = e_neg;
        n_acc  = e_acc;
        n_ds   = e_ds;
        n_pos  = advance ? pos_inc : e_pos;
        n_pend = pre ? e_pos : e_pend;
        if (take) begin
            n_base = tb;
        end
        if (x_pre) begin
            n_base = aip_pkg::RADIX_HEX;
        end
        if (b_pre) begin
            n_base = aip_pkg::RADIX_BIN;
        end
        if (sign_take && is_minus) begin
            n_neg = 1'b1;
        end
        if (lead_zero) begin
            n_acc = '0;
            n_ds  = aip_pkg::ST_VALID;
        end
        if (accept_digit && e_ds != aip_pkg::ST_OVF) begin
            if (ovf) begin
                n_ds = aip_pkg::ST_OVF;
            end else begin
                n_acc = prod[VB-1:0];
                n_ds  = aip_pkg::ST_VALID;
            end
        end
    end

    always_comb begin
        o_emit   = bad_radix || prefix_fail || finish;
        o_result = '{value: '0, end_offset: '0, status: aip_pkg::ST_NONE};
        if (prefix_fail) begin
            o_result.end_offset = e_pend;
            o_result.status     = aip_pkg::ST_VALID;
        end else if (finish && e_ds != aip_pkg::ST_NONE) begin
            o_result.end_offset = e_pos;
            o_result.status     = e_ds;
            if (e_ds == aip_pkg::ST_OVF) begin
                o_result.value = $signed(e_neg ? VAL_MIN : VAL_MAX);
            end else begin
                o_result.value = $signed(e_neg ? -e_acc : e_acc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aip_pkg::PH_DONE;
            r_base  <= '0;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_ds    <= aip_pkg::ST_NONE;
            r_pos   <= '0;
            r_pend  <= '0;
        end else begin
            r_phase <= n_phase;
            if (i_fire) begin
                r_base <= n_base;
                r_neg  <= n_neg;
                r_acc  <= n_acc;
                r_ds   <= n_ds;
                r_pos  <= n_pos;
                r_pend <= n_pend;
            end
        end
    end

    `AIP_ASSERT_ALWAYS(a_ds_code, i_clk, i_rst_n, r_ds != 2'd3, "digit status holds an unused code")
    `AIP_ASSERT_NEXT(a_emit_done, i_clk, i_rst_n, i_fire && o_emit, r_phase == aip_pkg::PH_DONE, "phase not done after result")
    `AIP_ASSERT_NEXT(a_digit_phase, i_clk, i_rst_n, i_fire && accept_digit, r_phase == aip_pkg::PH_DIGITS && r_ds != aip_pkg::ST_NONE, "digit taken without entering digit phase")
    `AIP_ASSERT_ALWAYS(a_prefix_base, i_clk, i_rst_n, r_phase != aip_pkg::PH_PREFIX || r_base == aip_pkg::RADIX_HEX || r_base == aip_pkg::RADIX_BIN, "prefix phase with a base other than 2 or 16")
    `AIP_ASSERT_ALWAYS(a_acc_limit, i_clk, i_rst_n, r_acc <= VAL_MIN, "accumulator beyond the signed limit")

endmodule

>>> hw/rtl/ascii_integer_parser_top.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_top
// Streaming strtol-style ASCII to signed integer converter.
// ----------------------------------------------------------------------------
// Takes one character item per clock while the output is not stalled, and
// returns one result item per parsed string, registered in the result
// register after the character that ends the string was held in the input
// register; the multiply-add and limit compare on the accumulator lie
// between the input register and the result register.
`timescale 1ns / 1ps

module ascii_integer_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  aip_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output aip_pkg::t_out_item o_out_item
);

    logic               r_in_vld;
    aip_pkg::t_in_item  r_in;
    logic               r_out_vld;
    aip_pkg::t_out_item r_out;
    logic               fire;
    logic               emit;
    aip_pkg::t_out_item result;

    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;

    aip_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule
